>>> rtl/ede_pkg.sv
package ede_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic accept_load;
        logic accept_query;
        logic accept_finish;
        logic cell_step;
        logic fin_wait;
        logic out_load;
    } ede_cmd_t;

    typedef struct packed {
        logic last_cell;
        logic query_full;
        logic ref_empty;
        logic out_free;
    } ede_status_t;

endpackage

>>> rtl/ede_ram.sv
module ede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ede_ctrl.sv
module ede_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [1:0]           in_cmd,
    input  ede_pkg::ede_status_t status,
    output ede_pkg::ede_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        cmd               = '0;
        state_next        = state_reg;
        cmd.accept_load   = accept && (in_cmd == ede_pkg::CMD_LOAD);
        cmd.accept_query  = accept && (in_cmd == ede_pkg::CMD_QUERY);
        cmd.accept_finish = accept && (in_cmd == ede_pkg::CMD_FINISH);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept_query && !status.query_full && !status.ref_empty) begin
                    state_next = ST_RUN;
                end else if (cmd.accept_finish) begin
                    state_next = ST_FIN;
                end
            end
            ST_RUN: begin
                cmd.cell_step = 1'b1;
                if (status.last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                cmd.fin_wait = 1'b1;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/ede_datapath.sv
module ede_datapath #(
    parameter int MAX_LEN = 64,
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int RAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            symbol,
    input  logic                  start_reference,
    input  ede_pkg::ede_cmd_t     cmd,
    output ede_pkg::ede_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LW-1:0]         m_distance,
    output logic                  m_overflow
);

    logic [LW-1:0]  ref_len_reg, ref_len_next;
    logic [LW-1:0]  q_len_reg, q_len_next;
    logic           exc_reg, exc_next;
    logic [LW-1:0]  ptr_reg, ptr_next;
    logic [LW-1:0]  diag_reg, diag_next;
    logic [LW-1:0]  left_reg, left_next;
    logic           fresh_reg, fresh_next;
    logic [7:0]     sym_reg, sym_next;
    logic           m_valid_reg, m_valid_next;
    logic [LW-1:0]  dist_reg, dist_next;
    logic           ovf_reg, ovf_next;

    logic [LW-1:0]  load_pos;
    logic           ref_we;
    logic [LW-1:0]  row_raddr;
    logic [RAW-1:0] ref_raddr;
    logic [LW-1:0]  row_rdata;
    logic [7:0]     ref_rdata;
    logic [LW:0]    above_w, sub_w, up_w, left_w, min_a, cell_w;
    logic [LW-1:0]  cell_val;

    assign status.last_cell  = (ptr_reg == ref_len_reg);
    assign status.query_full = (q_len_reg == LW'(MAX_LEN));
    assign status.ref_empty  = (ref_len_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign load_pos = start_reference ? '0 : ref_len_reg;
    assign ref_we   = cmd.accept_load && (load_pos != LW'(MAX_LEN));

    always_comb begin
        if (cmd.accept_finish || cmd.fin_wait) begin
            row_raddr = ref_len_reg;
        end else if (cmd.cell_step) begin
            row_raddr = status.last_cell ? ptr_reg : ptr_reg + LW'(1);
        end else begin
            row_raddr = LW'(1);
        end
        ref_raddr = (cmd.accept_finish || cmd.fin_wait) ? '0 : RAW'(row_raddr - LW'(1));
    end

    ede_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (RAW'(load_pos)),
        .wdata (symbol),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    ede_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_row_ram (
        .aclk  (aclk),
        .we    (cmd.cell_step),
        .waddr (ptr_reg),
        .wdata (cell_val),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    always_comb begin
        above_w  = {1'b0, fresh_reg ? ptr_reg : row_rdata};
        sub_w    = {1'b0, diag_reg} + {{LW{1'b0}}, (ref_rdata != sym_reg)};
        up_w     = above_w + (LW + 1)'(1);
        left_w   = {1'b0, left_reg} + (LW + 1)'(1);
        min_a    = (sub_w < up_w) ? sub_w : up_w;
        cell_w   = (min_a < left_w) ? min_a : left_w;
        cell_val = cell_w[LW-1:0];
    end

    always_comb begin
        ref_len_next = ref_len_reg;
        q_len_next   = q_len_reg;
        exc_next     = exc_reg;
        ptr_next     = ptr_reg;
        diag_next    = diag_reg;
        left_next    = left_reg;
        fresh_next   = fresh_reg;
        sym_next     = sym_reg;
        m_valid_next = m_valid_reg && !m_ready;
        dist_next    = dist_reg;
        ovf_next     = ovf_reg;

        if (cmd.accept_load) begin
            if (start_reference) begin
                exc_next = 1'b0;
            end
            if (load_pos == LW'(MAX_LEN)) begin
                exc_next     = 1'b1;
                ref_len_next = load_pos;
            end else begin
                ref_len_next = load_pos + LW'(1);
            end
            q_len_next = '0;
        end

        if (cmd.accept_query) begin
            if (status.query_full) begin
                exc_next = 1'b1;
            end else begin
                q_len_next = q_len_reg + LW'(1);
                sym_next   = symbol;
                diag_next  = q_len_reg;
                left_next  = q_len_reg + LW'(1);
                fresh_next = (q_len_reg == '0);
                ptr_next   = LW'(1);
            end
        end

        if (cmd.cell_step) begin
            diag_next = above_w[LW-1:0];
            left_next = cell_val;
            if (!status.last_cell) begin
                ptr_next = ptr_reg + LW'(1);
            end
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            ovf_next     = exc_reg;
            q_len_next   = '0;
            priority if (q_len_reg == '0) begin
                dist_next = ref_len_reg;
            end else if (status.ref_empty) begin
                dist_next = q_len_reg;
            end else begin
                dist_next = row_rdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_len_reg <= '0;
            q_len_reg   <= '0;
            exc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ref_len_reg <= ref_len_next;
            q_len_reg   <= q_len_next;
            exc_reg     <= exc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        diag_reg  <= diag_next;
        left_reg  <= left_next;
        fresh_reg <= fresh_next;
        sym_reg   <= sym_next;
        dist_reg  <= dist_next;
        ovf_reg   <= ovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = dist_reg;
    assign m_overflow = ovf_reg;

endmodule

>>> rtl/edit_distance_engine.sv
// Levenshtein edit distance between a stored reference and a streamed query.
// Input beats (s_axis): tuser carries the command and start bit, tdata the
// character. Load beats append a reference character (start bit clears the
// reference first) and drop any query in progress. Query beats advance the
// cost row by one query character. Finish beats emit one m_axis beat with the
// distance and the sticky overflow flag, then restart the row.
// Per beat: a load is done once accepted; a query sweeps the cost row,
// since a single min cell steps through the cost row memory one entry per
// cycle; a finish does one row memory read, then loads the output register
// once it is free, and the result shows on m_axis the cycle after that.
// s_axis_tready is low while a query sweep or a finish is in progress.
// The output register holds its beat while m_axis_tready is low; loads and
// queries are still accepted, a further finish waits until the beat is taken.
// Reset clears the reference length, query length, overflow flag and output
// valid; the reference and cost row memories need no clearing pass.
module edit_distance_engine #(
    parameter int MAX_LEN = 64,
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int OUT_W = ((LW + 1 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // symbol
    input  logic [2:0]       s_axis_tuser,   // cmd[1:0], start_reference
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // distance[LW-1:0], overflow
);

    ede_pkg::ede_cmd_t    cmd;
    ede_pkg::ede_status_t status;
    logic [LW-1:0]        distance;
    logic                 overflow;

    ede_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_cmd        (s_axis_tuser[1:0]),
        .status        (status),
        .cmd           (cmd)
    );

    ede_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .symbol          (s_axis_tdata),
        .start_reference (s_axis_tuser[2]),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_distance      (distance),
        .m_overflow      (overflow)
    );

    assign m_axis_tdata = OUT_W'({overflow, distance});

endmodule

>>> rtl/ede_checker.sv
module ede_checker #(
    parameter int MAX_LEN = 64,
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int OUT_W = ((LW + 1 + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[LW-1:0] <= LW'(MAX_LEN)))
        else $error("distance beyond maximum length");

    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat without finish in progress");

endmodule

bind edit_distance_engine ede_checker #(.MAX_LEN(MAX_LEN)) u_ede_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
